### design/slaw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slaw_pkg
// Shared types, codes and sizes of the scan line assembler with watchdog.
// ----------------------------------------------------------------------------
package slaw_pkg;

    localparam int LINE_MAX   = 64;
    localparam int LINE_AW    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int FILL_W     = $clog2(LINE_MAX + 1);
    localparam int CMDQ_DEPTH = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WD_INTERVAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR    = 2'd3;

    localparam logic [15:0] STALL_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0] WD_INTERVAL_RST   = 16'd1000;
    localparam logic [15:0] RECOVERY_RST      = 16'd2000;
    localparam logic [7:0]  TERMINATOR_RST    = 8'd13;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RECOVER = 2'd2;

    localparam logic [1:0] MODE_READY      = 2'd0;
    localparam logic [1:0] MODE_SCANNING   = 2'd1;
    localparam logic [1:0] MODE_RECOVERING = 2'd2;

    localparam logic [7:0]  LF_BYTE     = 8'h0A;
    localparam logic [16:0] SILENCE_MAX = 17'h1FFFF;
    localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

    typedef struct packed {
        logic        drop;
        logic        stall;
        logic        done;
        logic        healthy;
        logic [1:0]  state;
        logic [31:0] bytes;
        logic [31:0] scans;
    } status_t;

    typedef struct packed {
        logic              is_line;
        logic [FILL_W-1:0] count;
        status_t           st;
    } cmd_t;

    typedef struct packed {
        logic        is_line_byte;
        logic [7:0]  line_byte;
        logic        line_end;
        status_t     st;
    } result_t;

endpackage
`default_nettype wire

### design/scan_line_assembler_watchdog_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scan_line_assembler_watchdog_unit
// Assembles received bytes into lines with a watchdog and a
// recovery mode; every item gives a status beat or a run of line byte beats.
// ----------------------------------------------------------------------------
// A status beat goes through the command queue into the output register, which
// holds it until popped. Throughput: one item per cycle while no line is being
// emitted and the four-item command queue is not full. A line of n bytes goes
// through the queue and the line store RAM read register and then gives one
// beat per cycle while the result is popped; full stays high until the last
// beat of the line is loaded. Reset: control registers return to their default
// values; the line store is not cleared and needs no clearing pass.
module scan_line_assembler_watchdog_unit
    import slaw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            action,
    input  logic [7:0]            rx_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  is_line_byte,
    output logic [7:0]            line_byte,
    output logic                  line_end,
    output logic                  overflow_drop,
    output logic                  stall_cleared,
    output logic                  recovery_done,
    output logic                  healthy,
    output logic [1:0]            scanner_state,
    output logic [31:0]           bytes_received,
    output logic [31:0]           scan_count
);

    logic               q_push;
    cmd_t               q_wdata;
    logic               q_pop;
    cmd_t               q_head;
    logic               q_empty;
    logic               q_full;
    logic               ram_we;
    logic [LINE_AW-1:0] ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [LINE_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;
    logic               line_done;
    logic               out_valid;
    result_t            out_beat;

    slaw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .action    (action),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .line_done (line_done)
    );

    slaw_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    slaw_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    slaw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .line_done (line_done),
        .out_valid (out_valid),
        .out_beat  (out_beat),
        .pop       (pop)
    );

    assign empty          = !out_valid;
    assign is_line_byte   = out_beat.is_line_byte;
    assign line_byte      = out_beat.line_byte;
    assign line_end       = out_beat.line_end;
    assign overflow_drop  = out_beat.st.drop;
    assign stall_cleared  = out_beat.st.stall;
    assign recovery_done  = out_beat.st.done;
    assign healthy        = out_beat.st.healthy;
    assign scanner_state  = out_beat.st.state;
    assign bytes_received = out_beat.st.bytes;
    assign scan_count     = out_beat.st.scans;

endmodule
`default_nettype wire

### design/slaw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slaw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slaw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### design/slaw_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slaw_cmdq
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module slaw_cmdq
    import slaw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_push,
    input  cmd_t q_wdata,
    input  logic q_pop,
    output cmd_t q_head,
    output logic q_empty,
    output logic q_full
);

    localparam int QA = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QC = $clog2(CMDQ_DEPTH + 1);

    cmd_t          entry_reg [CMDQ_DEPTH];
    logic [QA-1:0] wr_ptr_reg;
    logic [QA-1:0] rd_ptr_reg;
    logic [QC-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == QC'(CMDQ_DEPTH));
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QA'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + QA'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QA'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + QA'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QC'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QC'(1);
            end
        end
    end

endmodule
`default_nettype wire

### design/slaw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slaw_front
// Accepts and classifies items, keeps the timers and counters, fills the line
// store and queues one command per item for the back part.
// ----------------------------------------------------------------------------
module slaw_front
    import slaw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            action,
    input  logic [7:0]            rx_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_wdata,
    output logic                  ram_we,
    output logic [LINE_AW-1:0]    ram_waddr,
    output logic [7:0]            ram_wdata,
    input  logic                  line_done
);

    logic [15:0]       stall_to_reg;
    logic [15:0]       interval_reg;
    logic [15:0]       delay_reg;
    logic [7:0]        term_reg;

    logic [FILL_W-1:0] fill_reg,       fill_next;
    logic [16:0]       silence_reg,    silence_next;
    logic [15:0]       wd_reg,         wd_next;
    logic [15:0]       rec_reg,        rec_next;
    logic              recovering_reg, recovering_next;
    logic              healthy_reg,    healthy_next;
    logic [1:0]        mode_reg,       mode_next;
    logic [31:0]       bytes_reg,      bytes_next;
    logic [31:0]       lines_reg,      lines_next;
    logic              line_busy_reg;

    logic              accept;
    logic              drop;
    logic              stall;
    logic              done;
    logic              emit_line;
    logic              is_term;

    assign full    = q_full || line_busy_reg;
    assign accept  = push && !full;
    assign is_term = (rx_byte == term_reg) || (rx_byte == LF_BYTE);

    always_comb
    begin
        fill_next       = fill_reg;
        silence_next    = silence_reg;
        wd_next         = wd_reg;
        rec_next        = rec_reg;
        recovering_next = recovering_reg;
        healthy_next    = healthy_reg;
        mode_next       = mode_reg;
        bytes_next      = bytes_reg;
        lines_next      = lines_reg;
        drop            = 1'b0;
        stall           = 1'b0;
        done            = 1'b0;
        emit_line       = 1'b0;
        ram_we          = 1'b0;

        case (action)
            ACT_BYTE:
            begin
                if (!recovering_reg)
                begin
                    bytes_next   = bytes_reg + 32'd1;
                    silence_next = '0;
                    if (mode_reg == MODE_READY)
                    begin
                        mode_next = MODE_SCANNING;
                    end
                    if (is_term)
                    begin
                        if (fill_reg != '0)
                        begin
                            emit_line  = 1'b1;
                            lines_next = lines_reg + 32'd1;
                            mode_next  = MODE_READY;
                            fill_next  = '0;
                        end
                    end
                    else if (fill_reg >= FILL_W'(LINE_MAX))
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ACT_TICK:
            begin
                wd_next = (wd_reg == TIMER_MAX) ? wd_reg : wd_reg + 16'd1;
                if (recovering_reg)
                begin
                    rec_next = (rec_reg == TIMER_MAX) ? rec_reg : rec_reg + 16'd1;
                    if (rec_next >= delay_reg)
                    begin
                        healthy_next    = 1'b1;
                        recovering_next = 1'b0;
                        silence_next    = '0;
                        fill_next       = '0;
                        mode_next       = MODE_READY;
                        done            = 1'b1;
                    end
                end
                else
                begin
                    silence_next = (silence_reg == SILENCE_MAX) ? silence_reg
                                                                : silence_reg + 17'd1;
                    if (wd_next >= interval_reg)
                    begin
                        wd_next = '0;
                        if (fill_reg != '0 && silence_next > {1'b0, stall_to_reg})
                        begin
                            fill_next = '0;
                            mode_next = MODE_READY;
                            stall     = 1'b1;
                        end
                    end
                end
            end
            ACT_RECOVER:
            begin
                recovering_next = 1'b1;
                rec_next        = '0;
                healthy_next    = 1'b0;
                fill_next       = '0;
                mode_next       = MODE_RECOVERING;
            end
            default:
            begin
            end
        endcase

        ram_we = ram_we && accept;
    end

    assign ram_waddr = fill_reg[LINE_AW-1:0];
    assign ram_wdata = rx_byte;

    assign q_push             = accept;
    assign q_wdata.is_line    = emit_line;
    assign q_wdata.count      = emit_line ? fill_reg : '0;
    assign q_wdata.st.drop    = drop;
    assign q_wdata.st.stall   = stall;
    assign q_wdata.st.done    = done;
    assign q_wdata.st.healthy = healthy_next && !recovering_next;
    assign q_wdata.st.state   = mode_next;
    assign q_wdata.st.bytes   = bytes_next;
    assign q_wdata.st.scans   = lines_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_to_reg   <= STALL_TIMEOUT_RST;
            interval_reg   <= WD_INTERVAL_RST;
            delay_reg      <= RECOVERY_RST;
            term_reg       <= TERMINATOR_RST;
            fill_reg       <= '0;
            silence_reg    <= '0;
            wd_reg         <= '0;
            rec_reg        <= '0;
            recovering_reg <= 1'b0;
            healthy_reg    <= 1'b1;
            mode_reg       <= MODE_READY;
            bytes_reg      <= '0;
            lines_reg      <= '0;
            line_busy_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STALL_TIMEOUT: stall_to_reg <= cfg_data;
                    CFG_WD_INTERVAL:   interval_reg <= cfg_data;
                    CFG_RECOVERY:      delay_reg    <= cfg_data;
                    CFG_TERMINATOR:    term_reg     <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                fill_reg       <= fill_next;
                silence_reg    <= silence_next;
                wd_reg         <= wd_next;
                rec_reg        <= rec_next;
                recovering_reg <= recovering_next;
                healthy_reg    <= healthy_next;
                mode_reg       <= mode_next;
                bytes_reg      <= bytes_next;
                lines_reg      <= lines_next;
            end
            if (accept && emit_line)
            begin
                line_busy_reg <= 1'b1;
            end
            else if (line_done)
            begin
                line_busy_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_MAX))
        else $error("Line store fill count exceeds capacity.");

    a_recover_mode: assert property (@(posedge clk) disable iff (!rst_n)
        recovering_reg |-> (mode_reg == MODE_RECOVERING && !healthy_reg))
        else $error("Recovery flag disagrees with mode or health.");
`endif

endmodule
`default_nettype wire

### design/slaw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slaw_back
// Takes commands from the queue, walks the line store for completed lines and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
module slaw_back
    import slaw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               q_head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               ram_re,
    output logic [LINE_AW-1:0] ram_raddr,
    input  logic [7:0]         ram_rdata,
    output logic               line_done,
    output logic               out_valid,
    output result_t            out_beat,
    input  logic               pop
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_DATA = 1'b1;

    logic              state_reg, state_next;
    logic [FILL_W-1:0] idx_reg,   idx_next;
    cmd_t              cur_reg,   cur_next;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              load;
    result_t           load_val;
    logic              out_free;
    logic              last;

    assign out_free = !out_valid_reg || pop;
    assign last     = (idx_reg + FILL_W'(1)) == cur_reg.count;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        q_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[LINE_AW-1:0];
        load       = 1'b0;
        load_val   = '0;
        line_done  = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_line)
                    begin
                        cur_next   = q_head;
                        idx_next   = '0;
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = B_DATA;
                    end
                    else
                    begin
                        load        = 1'b1;
                        load_val.st = q_head.st;
                    end
                end
            end
            B_DATA:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    load_val.is_line_byte = 1'b1;
                    load_val.line_byte    = ram_rdata;
                    load_val.line_end     = last;
                    load_val.st           = cur_reg.st;
                    if (last)
                    begin
                        line_done  = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + FILL_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = idx_next[LINE_AW-1:0];
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        if (load)
        begin
            out_reg <= load_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

`ifndef NO_ASSERTIONS
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DATA |-> (cur_reg.count != '0 && idx_reg < cur_reg.count))
        else $error("Line walk index outside the line.");

    a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |-> (state_reg == B_DATA && load))
        else $error("Line completion without a final beat.");

    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |=> (out_valid_reg && out_reg.line_end && out_reg.is_line_byte))
        else $error("Final line beat not marked as line end.");
`endif

endmodule
`default_nettype wire
